// File: sv/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types, field tags, register indexes and reset values of the
// remote-control frame decoder with link watchdog.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 18;
    localparam int POS_W       = 5;

    typedef logic [POS_W-1:0]           pos_t;
    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;
    typedef logic [4:0]                 tag_t;
    typedef logic signed [16:0]         value_t;
    typedef logic signed [11:0]         chan_t;

    localparam pos_t POS_LAST = POS_W'(FRAME_BYTES - 1);
    localparam pos_t POS_IDLE = POS_W'(FRAME_BYTES);

    // Input request kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result tags
    localparam tag_t TAG_CH0       = 5'd0;
    localparam tag_t TAG_CH1       = 5'd1;
    localparam tag_t TAG_CH2       = 5'd2;
    localparam tag_t TAG_CH3       = 5'd3;
    localparam tag_t TAG_CH4       = 5'd4;
    localparam tag_t TAG_SW0       = 5'd5;
    localparam tag_t TAG_SW1       = 5'd6;
    localparam tag_t TAG_MOUSE_X   = 5'd7;
    localparam tag_t TAG_MOUSE_Y   = 5'd8;
    localparam tag_t TAG_MOUSE_Z   = 5'd9;
    localparam tag_t TAG_BTN_L     = 5'd10;
    localparam tag_t TAG_BTN_R     = 5'd11;
    localparam tag_t TAG_KEYS      = 5'd12;
    localparam tag_t TAG_VEL_FWD   = 5'd13;
    localparam tag_t TAG_VEL_SIDE  = 5'd14;
    localparam tag_t TAG_VEL_TURN  = 5'd15;
    localparam tag_t TAG_VEL_LIFT  = 5'd16;
    localparam tag_t TAG_COUNT     = 5'd17;

    // Configuration register map
    localparam int APB_ADDR_W = 5;
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_ONLINE_RELOAD  = 3'd0;
    localparam reg_idx_t REG_LOST_THRESHOLD = 3'd1;
    localparam reg_idx_t REG_CHANNEL_CENTER = 3'd2;
    localparam reg_idx_t REG_GAIN_FORWARD   = 3'd3;
    localparam reg_idx_t REG_GAIN_SIDEWAYS  = 3'd4;
    localparam reg_idx_t REG_GAIN_TURN      = 3'd5;
    localparam reg_idx_t REG_GAIN_LIFT      = 3'd6;

    localparam logic [7:0]  RST_ONLINE_RELOAD  = 8'd250;
    localparam logic [7:0]  RST_LOST_THRESHOLD = 8'd50;
    localparam logic [10:0] RST_CHANNEL_CENTER = 11'd1024;
    localparam logic [15:0] RST_GAIN_FORWARD   = 16'd3972;
    localparam logic [15:0] RST_GAIN_SIDEWAYS  = 16'd3972;
    localparam logic [15:0] RST_GAIN_TURN      = 16'd4766;
    localparam logic [15:0] RST_GAIN_LIFT      = 16'd794;

    typedef struct packed {
        logic [7:0]  online_reload;
        logic [7:0]  lost_threshold;
        logic [10:0] channel_center;
        logic [15:0] gain_forward;
        logic [15:0] gain_sideways;
        logic [15:0] gain_turn;
        logic [15:0] gain_lift;
    } cfg_t;

    // Start of a result run, from the frame assembler to the emitter
    typedef struct packed {
        logic       frame;
        logic       tick;
        logic [7:0] count;
        logic       lost;
    } launch_t;

endpackage

// File: sv/rcfd_regs.sv
// ----------------------------------------------------------------------------
// rcfd_regs
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module rcfd_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rcfd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output rcfd_pkg::cfg_t                   cfg
);

    rcfd_pkg::cfg_t     cfg_reg;
    rcfd_pkg::cfg_t     cfg_next;
    rcfd_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Update the addressed register on the access phase of a write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                rcfd_pkg::REG_ONLINE_RELOAD:  cfg_next.online_reload  = pwdata[7:0];
                rcfd_pkg::REG_LOST_THRESHOLD: cfg_next.lost_threshold = pwdata[7:0];
                rcfd_pkg::REG_CHANNEL_CENTER: cfg_next.channel_center = pwdata[10:0];
                rcfd_pkg::REG_GAIN_FORWARD:   cfg_next.gain_forward   = pwdata[15:0];
                rcfd_pkg::REG_GAIN_SIDEWAYS:  cfg_next.gain_sideways  = pwdata[15:0];
                rcfd_pkg::REG_GAIN_TURN:      cfg_next.gain_turn      = pwdata[15:0];
                rcfd_pkg::REG_GAIN_LIFT:      cfg_next.gain_lift      = pwdata[15:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.online_reload  <= rcfd_pkg::RST_ONLINE_RELOAD;
            cfg_reg.lost_threshold <= rcfd_pkg::RST_LOST_THRESHOLD;
            cfg_reg.channel_center <= rcfd_pkg::RST_CHANNEL_CENTER;
            cfg_reg.gain_forward   <= rcfd_pkg::RST_GAIN_FORWARD;
            cfg_reg.gain_sideways  <= rcfd_pkg::RST_GAIN_SIDEWAYS;
            cfg_reg.gain_turn      <= rcfd_pkg::RST_GAIN_TURN;
            cfg_reg.gain_lift      <= rcfd_pkg::RST_GAIN_LIFT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_idx)
            rcfd_pkg::REG_ONLINE_RELOAD:  prdata = {24'd0, cfg_reg.online_reload};
            rcfd_pkg::REG_LOST_THRESHOLD: prdata = {24'd0, cfg_reg.lost_threshold};
            rcfd_pkg::REG_CHANNEL_CENTER: prdata = {21'd0, cfg_reg.channel_center};
            rcfd_pkg::REG_GAIN_FORWARD:   prdata = {16'd0, cfg_reg.gain_forward};
            rcfd_pkg::REG_GAIN_SIDEWAYS:  prdata = {16'd0, cfg_reg.gain_sideways};
            rcfd_pkg::REG_GAIN_TURN:      prdata = {16'd0, cfg_reg.gain_turn};
            rcfd_pkg::REG_GAIN_LIFT:      prdata = {16'd0, cfg_reg.gain_lift};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

// File: sv/rcfd_assembler.sv
// ----------------------------------------------------------------------------
// rcfd_assembler
// Collects frame bytes, keeps the link watchdog and launches result runs.
// ----------------------------------------------------------------------------
module rcfd_assembler
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rcfd_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [7:0]           byte_value,
    input  logic                 frame_start,
    input  logic                 emit_busy,
    output rcfd_pkg::launch_t    launch,
    output rcfd_pkg::frame_t     frame_view
);

    rcfd_pkg::pos_t   pos_reg;
    rcfd_pkg::pos_t   pos_next;
    rcfd_pkg::pos_t   pos_eff;
    logic [7:0]       count_reg;
    logic [7:0]       count_next;
    logic             lost_reg;
    logic             lost_next;
    rcfd_pkg::frame_t bytes_reg;

    logic             is_tick;
    logic             byte_store;
    logic             frame_done;
    logic             accept;

    // Byte slot after an optional restart
    assign pos_eff    = frame_start ? '0 : pos_reg;
    assign is_tick    = (op == rcfd_pkg::OP_TICK);
    assign byte_store = !is_tick && (pos_eff != rcfd_pkg::POS_IDLE);
    assign frame_done = !is_tick && (pos_eff == rcfd_pkg::POS_LAST);

    // Hold only requests that would start a run while one is still draining
    assign in_ready = !(emit_busy && (is_tick || frame_done));
    assign accept   = in_valid && in_ready;

    // Frame position and watchdog
    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        lost_next  = lost_reg;
        if (accept)
        begin
            if (is_tick)
            begin
                if (count_reg <= cfg.lost_threshold)
                begin
                    lost_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg - 8'd1;
                end
            end
            else
            begin
                if (byte_store)
                begin
                    pos_next = pos_eff + rcfd_pkg::pos_t'(1);
                end
                else
                begin
                    pos_next = pos_eff;
                end
                if (frame_done)
                begin
                    count_next = cfg.online_reload;
                    lost_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= rcfd_pkg::POS_IDLE;
            count_reg <= rcfd_pkg::RST_ONLINE_RELOAD;
            lost_reg  <= 1'b1;
        end
        else
        begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            lost_reg  <= lost_next;
        end
    end

    // Store the byte at its slot
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < rcfd_pkg::FRAME_BYTES; i++)
        begin
            if (accept && byte_store && (pos_eff == rcfd_pkg::pos_t'(i)))
            begin
                bytes_reg[i] <= byte_value;
            end
        end
    end

    // Complete frame as seen with the final byte in place
    always_comb
    begin
        frame_view = bytes_reg;
        frame_view[rcfd_pkg::FRAME_BYTES-1] = byte_value;
    end

    assign launch.frame = accept && frame_done;
    assign launch.tick  = accept && is_tick;
    assign launch.count = count_next;
    assign launch.lost  = lost_next;

endmodule

// File: sv/rcfd_emitter.sv
// ----------------------------------------------------------------------------
// rcfd_emitter
// Holds a decoded frame or tick report; sends its tagged results one per cycle
// when not stalled, via a shared velocity multiplier into the output register.
// ----------------------------------------------------------------------------
module rcfd_emitter
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rcfd_pkg::cfg_t       cfg,
    input  rcfd_pkg::launch_t    launch,
    input  rcfd_pkg::frame_t     frame_view,
    output logic                 busy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rcfd_pkg::tag_t       out_tag,
    output rcfd_pkg::value_t     out_value,
    output logic                 out_lost,
    output logic                 out_last
);

    // Run state
    logic             run_valid_reg;
    logic             run_valid_next;
    logic             run_tick_reg;
    rcfd_pkg::tag_t   run_idx_reg;
    rcfd_pkg::tag_t   run_idx_next;
    logic [7:0]       run_count_reg;
    logic             run_lost_reg;
    rcfd_pkg::frame_t run_bytes_reg;
    rcfd_pkg::chan_t  run_ch_reg [5];

    // Output register
    logic             out_valid_reg;
    rcfd_pkg::tag_t   out_tag_reg;
    rcfd_pkg::value_t out_value_reg;
    logic             out_lost_reg;
    logic             out_last_reg;

    logic             out_load;
    logic             step;
    logic             run_last;
    logic             run_done;
    logic             launch_any;

    logic [10:0]      raw [5];
    rcfd_pkg::chan_t  ch_next [5];

    rcfd_pkg::chan_t  vel_ch;
    logic [15:0]      vel_gain;
    logic signed [28:0] vel_prod;
    logic signed [20:0] vel_shift;
    logic [15:0]      vel_sat;

    rcfd_pkg::tag_t   res_tag;
    rcfd_pkg::value_t res_value;

    assign out_load   = !out_valid_reg || out_ready;
    assign step       = run_valid_reg && out_load;
    assign run_last   = run_tick_reg || (run_idx_reg == rcfd_pkg::TAG_VEL_LIFT);
    assign run_done   = step && run_last;
    assign busy       = run_valid_reg && !run_done;
    assign launch_any = launch.frame || launch.tick;

    // Unpack raw channels and centre them as the frame is taken
    always_comb
    begin
        raw[0] = {frame_view[1][2:0], frame_view[0]};
        raw[1] = {frame_view[2][5:0], frame_view[1][7:3]};
        raw[2] = {frame_view[4][0], frame_view[3], frame_view[2][7:6]};
        raw[3] = {frame_view[5][3:0], frame_view[4][7:1]};
        raw[4] = {frame_view[17][2:0], frame_view[16]};
        for (int i = 0; i < 5; i++)
        begin
            ch_next[i] = $signed({1'b0, raw[i]}) - $signed({1'b0, cfg.channel_center});
        end
    end

    // Advance the run
    always_comb
    begin
        run_valid_next = run_valid_reg;
        run_idx_next   = run_idx_reg;
        if (run_done)
        begin
            run_valid_next = 1'b0;
        end
        else if (step)
        begin
            run_idx_next = run_idx_reg + rcfd_pkg::tag_t'(1);
        end
        if (launch_any)
        begin
            run_valid_next = 1'b1;
            run_idx_next   = rcfd_pkg::TAG_CH0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            run_idx_reg   <= rcfd_pkg::TAG_CH0;
            run_tick_reg  <= 1'b0;
        end
        else
        begin
            run_valid_reg <= run_valid_next;
            run_idx_reg   <= run_idx_next;
            if (launch_any)
            begin
                run_tick_reg <= launch.tick;
            end
        end
    end

    // Capture the frame or the tick report
    always_ff @(posedge clk)
    begin
        if (launch.frame)
        begin
            run_bytes_reg <= frame_view;
            for (int i = 0; i < 5; i++)
            begin
                run_ch_reg[i] <= ch_next[i];
            end
        end
        if (launch.tick)
        begin
            run_count_reg <= launch.count;
            run_lost_reg  <= launch.lost;
        end
    end

    // Pick the channel and gain of the velocity in turn
    always_comb
    begin
        case (run_idx_reg)
            rcfd_pkg::TAG_VEL_FWD:
            begin
                vel_ch   = run_ch_reg[2];
                vel_gain = cfg.gain_forward;
            end
            rcfd_pkg::TAG_VEL_SIDE:
            begin
                vel_ch   = run_ch_reg[3];
                vel_gain = cfg.gain_sideways;
            end
            rcfd_pkg::TAG_VEL_TURN:
            begin
                vel_ch   = run_ch_reg[0];
                vel_gain = cfg.gain_turn;
            end
            default:
            begin
                vel_ch   = run_ch_reg[1];
                vel_gain = cfg.gain_lift;
            end
        endcase
    end

    // Scale, floor by 256 and saturate to 16 bits
    assign vel_prod  = vel_ch * $signed({1'b0, vel_gain});
    assign vel_shift = vel_prod[28:8];

    always_comb
    begin
        if (vel_shift[20:15] == 6'b000000 || vel_shift[20:15] == 6'b111111)
        begin
            vel_sat = vel_shift[15:0];
        end
        else if (vel_shift[20])
        begin
            vel_sat = 16'h8000;
        end
        else
        begin
            vel_sat = 16'h7FFF;
        end
    end

    // Select the field of the current result
    always_comb
    begin
        res_tag = run_tick_reg ? rcfd_pkg::TAG_COUNT : run_idx_reg;
        case (res_tag)
            rcfd_pkg::TAG_CH0:      res_value = 17'(run_ch_reg[0]);
            rcfd_pkg::TAG_CH1:      res_value = 17'(run_ch_reg[1]);
            rcfd_pkg::TAG_CH2:      res_value = 17'(run_ch_reg[2]);
            rcfd_pkg::TAG_CH3:      res_value = 17'(run_ch_reg[3]);
            rcfd_pkg::TAG_CH4:      res_value = 17'(run_ch_reg[4]);
            rcfd_pkg::TAG_SW0:      res_value = {15'd0, run_bytes_reg[5][5:4]};
            rcfd_pkg::TAG_SW1:      res_value = {15'd0, run_bytes_reg[5][7:6]};
            rcfd_pkg::TAG_MOUSE_X:  res_value = {run_bytes_reg[7][7], run_bytes_reg[7],
                                                 run_bytes_reg[6]};
            rcfd_pkg::TAG_MOUSE_Y:  res_value = {run_bytes_reg[9][7], run_bytes_reg[9],
                                                 run_bytes_reg[8]};
            rcfd_pkg::TAG_MOUSE_Z:  res_value = {run_bytes_reg[11][7], run_bytes_reg[11],
                                                 run_bytes_reg[10]};
            rcfd_pkg::TAG_BTN_L:    res_value = {9'd0, run_bytes_reg[12]};
            rcfd_pkg::TAG_BTN_R:    res_value = {9'd0, run_bytes_reg[13]};
            rcfd_pkg::TAG_KEYS:     res_value = {1'b0, run_bytes_reg[15], run_bytes_reg[14]};
            rcfd_pkg::TAG_VEL_FWD,
            rcfd_pkg::TAG_VEL_SIDE,
            rcfd_pkg::TAG_VEL_TURN,
            rcfd_pkg::TAG_VEL_LIFT: res_value = {vel_sat[15], vel_sat};
            rcfd_pkg::TAG_COUNT:    res_value = {9'd0, run_count_reg};
            default:                res_value = '0;
        endcase
    end

    // Output register: load whenever it is empty or being taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= run_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_tag_reg   <= res_tag;
            out_value_reg <= res_value;
            out_lost_reg  <= run_tick_reg && run_lost_reg;
            out_last_reg  <= run_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_value = out_value_reg;
    assign out_lost  = out_lost_reg;
    assign out_last  = out_last_reg;

endmodule

// File: sv/rc_frame_decoder_with_link_watchdog.sv
// Path: a tick report or the first result of a frame passes the run registers
// and then the output register; the rest follow one per cycle unless stalled.
// Throughput: one request per cycle. A tick or a frame-closing byte is held
// while the previous run (17 results for a frame, one for a tick) drains.
// Reset: asynchronous, active low; waits for a start byte, link lost, count 250.
// ----------------------------------------------------------------------------
// rc_frame_decoder_with_link_watchdog
// Remote-control frame decoder: assembles 18-byte frames, emits 17 tagged
// fields per frame and keeps a link watchdog driven by tick requests.
// ----------------------------------------------------------------------------
module rc_frame_decoder_with_link_watchdog
(
    input  logic                             clk,
    input  logic                             rst_n,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rcfd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [7:0] byte_value
    input  logic [1:0]                       s_tuser,  // [0] op, [1] frame_start
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,  // [16:0] field_value, rest zero
    output logic [5:0]                       m_tuser,  // [4:0] field_tag, [5] link_lost
    output logic                             m_tlast   // last_of_run
);

    rcfd_pkg::cfg_t    cfg;
    rcfd_pkg::launch_t launch;
    rcfd_pkg::frame_t  frame_view;
    logic              emit_busy;
    rcfd_pkg::tag_t    out_tag;
    rcfd_pkg::value_t  out_value;
    logic              out_lost;

    rcfd_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcfd_assembler u_assembler
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .op          (s_tuser[0]),
        .byte_value  (s_tdata),
        .frame_start (s_tuser[1]),
        .emit_busy   (emit_busy),
        .launch      (launch),
        .frame_view  (frame_view)
    );

    rcfd_emitter u_emitter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .launch     (launch),
        .frame_view (frame_view),
        .busy       (emit_busy),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_tag    (out_tag),
        .out_value  (out_value),
        .out_lost   (out_lost),
        .out_last   (m_tlast)
    );

    // Pack the result fields
    assign m_tdata = {7'd0, out_value};
    assign m_tuser = {out_lost, out_tag};

endmodule

// File: sv/rcfd_checker.sv
// ----------------------------------------------------------------------------
// rcfd_checker
// Port-level checks on the result stream of the frame decoder.
// ----------------------------------------------------------------------------
module rcfd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [5:0]  m_tuser,
    input logic        m_tlast
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Tags stay within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[4:0] <= rcfd_pkg::TAG_COUNT)
        else $error("undefined field tag");

    // Only the final velocity or a watchdog report closes a run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |->
            m_tuser[4:0] == rcfd_pkg::TAG_VEL_LIFT || m_tuser[4:0] == rcfd_pkg::TAG_COUNT)
        else $error("run closed on the wrong tag");

    // A watchdog report always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4:0] == rcfd_pkg::TAG_COUNT |-> m_tlast)
        else $error("watchdog report without last");

    // Link loss is only flagged on watchdog reports
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4:0] != rcfd_pkg::TAG_COUNT |-> !m_tuser[5])
        else $error("loss flag set inside a frame run");

endmodule

bind rc_frame_decoder_with_link_watchdog rcfd_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
